// ===== rtl/core/stp_pkg.sv =====
`default_nettype none

package stp_pkg;

    // Field widths of the channels and registers.
    localparam int MAX_STRINGS = 6;
    localparam int PERIOD_W    = 12;
    localparam int TOP_W       = 16;
    localparam int LEVEL_W     = 10;
    localparam int ROW_W       = 8;
    localparam int MODE_W      = 6;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;

    // Dividend width of the serial divider: counter plus offset needs 17 bits.
    localparam int DVD_W       = TOP_W + 1;
    localparam int DCNT_W      = $clog2(DVD_W);

    // Parameter defaults.
    localparam int NUM_STRINGS_DEF = 6;
    localparam int SEGMENTS_DEF    = 8;

    // Reset values of the registers.
    localparam logic [PERIOD_W-1:0] PERIOD_RESET [MAX_STRINGS] = '{
        12'd3035, 12'd2275, 12'd1705, 12'd1275, 12'd1010, 12'd758
    };
    localparam logic [TOP_W-1:0]   TOP_RESET   = 16'd62400;
    localparam logic [LEVEL_W-1:0] LEVEL_RESET = 10'd0;

    // Shown-string code for all strings.
    localparam logic [2:0] ALL_SHOWN = 3'd6;

    // Register indexes on the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_0        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_1        = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_2        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_3        = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_4        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_PERIOD_5        = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_COUNTER_TOP     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_THRESHOLD = 3'd7;

    // Item commands.
    localparam logic CMD_WRAP  = 1'b0;
    localparam logic CMD_FRAME = 1'b1;

endpackage

`default_nettype wire

// ===== rtl/core/stp_item_if.sv =====
`default_nettype none

interface stp_item_if
    import stp_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               cmd;
    logic [TOP_W-1:0]   counter_value;
    logic [LEVEL_W-1:0] level_sample;
    logic               button_down;

    modport source (output valid, cmd, counter_value, level_sample, button_down,
                    input ready);
    modport sink   (input valid, cmd, counter_value, level_sample, button_down,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stp_result_if.sv =====
`default_nettype none

interface stp_result_if
    import stp_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [ROW_W-1:0]  row_0;
    logic [ROW_W-1:0]  row_1;
    logic [ROW_W-1:0]  row_2;
    logic [ROW_W-1:0]  row_3;
    logic [ROW_W-1:0]  row_4;
    logic [ROW_W-1:0]  row_5;
    logic [MODE_W-1:0] mode_row;

    modport source (output valid, row_0, row_1, row_2, row_3, row_4, row_5, mode_row,
                    input ready);
    modport sink   (input valid, row_0, row_1, row_2, row_3, row_4, row_5, mode_row,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/stp_cfg_if.sv =====
`default_nettype none

interface stp_cfg_if
    import stp_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/strobe_tuner_pattern.sv =====
`default_nettype none

// Channel   Role  Payload
// item      sink  cmd, counter_value, level_sample, button_down
// result    src   row_0 .. row_5, mode_row (one item per frame, none per wrap)
// cfg       sink  index, data (always ready)
//
// One restoring divider, one dividend bit per cycle.
// A string runs a load step, two divisions and two post steps; a skipped
// string runs only its load step. A frame then passes the emit step into
// the output register; a wrap item returns to idle.
// Reset (rst_n low, asynchronous) restores register defaults and clears state.
// A full output register holds a new frame in its emit step and stalls input.

module strobe_tuner_pattern
    import stp_pkg::*;
#(
    parameter int NUM_STRINGS = NUM_STRINGS_DEF,
    parameter int SEGMENTS    = SEGMENTS_DEF
)
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    stp_item_if.sink          item,
    stp_result_if.source      result,
    stp_cfg_if.sink           cfg
);

    localparam int StrW = (NUM_STRINGS > 1) ? $clog2(NUM_STRINGS) : 1;
    localparam logic [StrW-1:0]   LastStr = StrW'(NUM_STRINGS - 1);
    localparam logic [2:0]        NumStr3 = 3'(NUM_STRINGS);
    localparam logic [MODE_W-1:0] AllMask = MODE_W'((1 << NUM_STRINGS) - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOAD,
        S_DIV,
        S_POST,
        S_EMIT
    } state_t;

    // Registers.
    state_t                state_reg, state_next;
    logic [PERIOD_W-1:0]   period_reg [MAX_STRINGS];
    logic [PERIOD_W-1:0]   period_next [MAX_STRINGS];
    logic [TOP_W-1:0]      top_reg, top_next;
    logic [LEVEL_W-1:0]    thr_reg, thr_next;
    logic [PERIOD_W-1:0]   offset_reg [NUM_STRINGS];
    logic [PERIOD_W-1:0]   offset_next [NUM_STRINGS];
    logic [2:0]            shown_reg, shown_next;
    logic                  was_down_reg, was_down_next;
    logic                  cmd_reg, cmd_next;
    logic [TOP_W-1:0]      cnt_reg, cnt_next;
    logic [LEVEL_W-1:0]    lvl_reg, lvl_next;
    logic [StrW-1:0]       idx_reg, idx_next;
    logic                  pass_reg, pass_next;
    logic [ROW_W-1:0]      rows_reg [NUM_STRINGS];
    logic [ROW_W-1:0]      rows_next [NUM_STRINGS];
    logic [DVD_W-1:0]      dvd_reg, dvd_next;
    logic [PERIOD_W-1:0]   rem_reg, rem_next;
    logic [2:0]            quo_reg, quo_next;
    logic [PERIOD_W-1:0]   div_per_reg, div_per_next;
    logic [DCNT_W-1:0]     dcnt_reg, dcnt_next;
    logic                  out_valid_reg, out_valid_next;
    logic [ROW_W-1:0]      out_rows_reg [MAX_STRINGS];
    logic [ROW_W-1:0]      out_rows_next [MAX_STRINGS];
    logic [MODE_W-1:0]     out_mode_reg, out_mode_next;

    // Shared combinational terms.
    logic                  item_acc;
    logic                  out_free;
    logic                  all_shown;
    logic [PERIOD_W-1:0]   cur_per;
    logic [PERIOD_W-1:0]   cur_off;
    logic                  cur_shown;
    logic [PERIOD_W:0]     trial;
    logic                  trial_ge;
    logic [DVD_W-1:0]      seg_base;
    logic [DVD_W-1:0]      seg_dvd;

    assign item.ready  = (state_reg == S_IDLE);
    assign cfg.ready   = 1'b1;
    assign item_acc    = item.valid && item.ready;
    assign out_free    = !out_valid_reg || result.ready;
    assign all_shown   = (shown_reg >= NumStr3);
    assign cur_per     = period_reg[3'(idx_reg)];
    assign cur_off     = offset_reg[idx_reg];
    assign cur_shown   = all_shown || (shown_reg == 3'(idx_reg));

    // One restoring division step: bring in the next dividend bit.
    assign trial    = {rem_reg, dvd_reg[DVD_W-1]};
    assign trial_ge = (trial >= {1'b0, div_per_reg});

    // Segment search: p = floor((SEGMENTS * (t + 1) - 1) / period).
    assign seg_base = DVD_W'(rem_reg) + DVD_W'(1);
    assign seg_dvd  = DVD_W'(seg_base * SEGMENTS) - DVD_W'(1);

    // Output ports.
    assign result.valid    = out_valid_reg;
    assign result.row_0    = out_rows_reg[0];
    assign result.row_1    = out_rows_reg[1];
    assign result.row_2    = out_rows_reg[2];
    assign result.row_3    = out_rows_reg[3];
    assign result.row_4    = out_rows_reg[4];
    assign result.row_5    = out_rows_reg[5];
    assign result.mode_row = out_mode_reg;

    // Next-state logic of the sequencer, divider and registers.
    always_comb
    begin
        state_next     = state_reg;
        period_next    = period_reg;
        top_next       = top_reg;
        thr_next       = thr_reg;
        offset_next    = offset_reg;
        shown_next     = shown_reg;
        was_down_next  = was_down_reg;
        cmd_next       = cmd_reg;
        cnt_next       = cnt_reg;
        lvl_next       = lvl_reg;
        idx_next       = idx_reg;
        pass_next      = pass_reg;
        rows_next      = rows_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        quo_next       = quo_reg;
        div_per_next   = div_per_reg;
        dcnt_next      = dcnt_reg;
        out_valid_next = out_valid_reg;
        out_rows_next  = out_rows_reg;
        out_mode_next  = out_mode_reg;

        // Configuration writes.
        if (cfg.valid)
        begin
            unique case (cfg.index) inside
                REG_PERIOD_0, REG_PERIOD_1, REG_PERIOD_2,
                REG_PERIOD_3, REG_PERIOD_4, REG_PERIOD_5:
                    period_next[cfg.index] = cfg.data[PERIOD_W-1:0];
                REG_COUNTER_TOP:
                    top_next = cfg.data[TOP_W-1:0];
                REG_LEVEL_THRESHOLD:
                    thr_next = cfg.data[LEVEL_W-1:0];
                default:
                    top_next = top_reg;
            endcase
        end

        // The output register empties when the item is taken.
        if (result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (item_acc)
                begin
                    cmd_next = item.cmd;
                    cnt_next = item.counter_value;
                    lvl_next = item.level_sample;
                    idx_next = '0;
                    for (int s = 0; s < NUM_STRINGS; s++)
                    begin
                        rows_next[s] = '0;
                    end
                    // Mode button: a release steps the shown string.
                    if (item.cmd == CMD_FRAME)
                    begin
                        if (item.button_down)
                        begin
                            was_down_next = 1'b1;
                        end
                        else
                        begin
                            if (was_down_reg)
                            begin
                                if (all_shown)
                                    shown_next = 3'd0;
                                else if (shown_reg + 3'd1 >= NumStr3)
                                    shown_next = ALL_SHOWN;
                                else
                                    shown_next = shown_reg + 3'd1;
                            end
                            was_down_next = 1'b0;
                        end
                    end
                    state_next = S_LOAD;
                end
            end

            S_LOAD:
            begin
                // Start the first division of this string, or skip it.
                pass_next    = 1'b0;
                div_per_next = cur_per;
                rem_next     = '0;
                quo_next     = '0;
                dcnt_next    = DCNT_W'(DVD_W - 1);
                if (cmd_reg == CMD_WRAP)
                begin
                    dvd_next = DVD_W'(top_reg);
                    if (cur_per == '0)
                    begin
                        offset_next[idx_reg] = '0;
                        if (idx_reg == LastStr)
                            state_next = S_IDLE;
                        else
                            idx_next = idx_reg + StrW'(1);
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
                else
                begin
                    dvd_next = DVD_W'(cnt_reg) + DVD_W'(cur_off);
                    if (!cur_shown || cur_per == '0 || lvl_reg <= thr_reg)
                    begin
                        if (idx_reg == LastStr)
                            state_next = S_EMIT;
                        else
                            idx_next = idx_reg + StrW'(1);
                    end
                    else
                    begin
                        state_next = S_DIV;
                    end
                end
            end

            S_DIV:
            begin
                // One quotient bit per cycle.
                dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
                rem_next = trial_ge ? PERIOD_W'(trial - {1'b0, div_per_reg})
                                    : trial[PERIOD_W-1:0];
                quo_next = {quo_reg[1:0], trial_ge};
                if (dcnt_reg == '0)
                    state_next = S_POST;
                else
                    dcnt_next = dcnt_reg - DCNT_W'(1);
            end

            S_POST:
            begin
                if (!pass_reg)
                begin
                    // Second division: offset update or segment search.
                    pass_next  = 1'b1;
                    dcnt_next  = DCNT_W'(DVD_W - 1);
                    quo_next   = '0;
                    state_next = S_DIV;
                    if (cmd_reg == CMD_WRAP)
                        dvd_next = DVD_W'(cur_off) + DVD_W'(rem_reg);
                    else
                        dvd_next = seg_dvd;
                    rem_next = '0;
                end
                else
                begin
                    if (cmd_reg == CMD_WRAP)
                        offset_next[idx_reg] = rem_reg;
                    else
                        rows_next[idx_reg] = ROW_W'(1) << quo_reg;
                    if (idx_reg == LastStr)
                    begin
                        state_next = (cmd_reg == CMD_WRAP) ? S_IDLE : S_EMIT;
                    end
                    else
                    begin
                        idx_next   = idx_reg + StrW'(1);
                        state_next = S_LOAD;
                    end
                end
            end

            S_EMIT:
            begin
                // Hand the frame to the output register once it is free.
                if (out_free)
                begin
                    for (int s = 0; s < MAX_STRINGS; s++)
                    begin
                        out_rows_next[s] = (s < NUM_STRINGS) ? rows_reg[s] : '0;
                    end
                    out_mode_next  = all_shown ? AllMask : MODE_W'(1) << shown_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            period_reg    <= PERIOD_RESET;
            top_reg       <= TOP_RESET;
            thr_reg       <= LEVEL_RESET;
            for (int s = 0; s < NUM_STRINGS; s++)
            begin
                offset_reg[s] <= '0;
            end
            shown_reg     <= ALL_SHOWN;
            was_down_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int s = 0; s < MAX_STRINGS; s++)
            begin
                out_rows_reg[s] <= '0;
            end
            out_mode_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            period_reg    <= period_next;
            top_reg       <= top_next;
            thr_reg       <= thr_next;
            offset_reg    <= offset_next;
            shown_reg     <= shown_next;
            was_down_reg  <= was_down_next;
            out_valid_reg <= out_valid_next;
            out_rows_reg  <= out_rows_next;
            out_mode_reg  <= out_mode_next;
        end
    end

    // Working registers of the sequencer and divider.
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        cnt_reg      <= cnt_next;
        lvl_reg      <= lvl_next;
        idx_reg      <= idx_next;
        pass_reg     <= pass_next;
        rows_reg     <= rows_next;
        dvd_reg      <= dvd_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_per_reg  <= div_per_next;
        dcnt_reg     <= dcnt_next;
    end

    // A result appears only after the emit step.
    a_emit_before_valid: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_EMIT))
        else $error("result raised outside the emit step");

    // The divider never runs on a zero period and keeps its remainder reduced.
    a_div_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (div_per_reg != '0 && rem_reg < div_per_reg))
        else $error("divider remainder out of range");

    // Each row lights at most one segment.
    a_rows_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($onehot0(out_rows_reg[0]) && $onehot0(out_rows_reg[1]) &&
                           $onehot0(out_rows_reg[2]) && $onehot0(out_rows_reg[3]) &&
                           $onehot0(out_rows_reg[4]) && $onehot0(out_rows_reg[5])))
        else $error("row with more than one segment lit");

    // The mode indicator is one string or all of them.
    a_mode_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($onehot(out_mode_reg) || out_mode_reg == AllMask))
        else $error("bad mode indicator");

endmodule

`default_nettype wire
